// File: rtl/triangle_face_normal_assert.svh
// Assertion macros for the triangle face normal block
`ifndef TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ASSERT_SVH

// Clocked assertion with reset disable and a fixed message
`define TFN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tfn assertion failed");

// Clocked assertion with reset disable and a caller message
`define TFN_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

// File: rtl/tfn_pkg.sv
// Shared constants for the triangle face normal block
`default_nettype none
package tfn_pkg;
  localparam int unsigned COORD_BITS_DEF    = 16;
  localparam int unsigned OUT_FRAC_BITS_DEF = 14;
  localparam int unsigned NORM_W            = 16;
  localparam int unsigned LANES             = 3;
endpackage
`default_nettype wire

// File: rtl/tfn_root_step.sv
// One bit of the rounded ratio mag * 2^F / sqrt(s), one lane, registered
`default_nettype none
module tfn_root_step #(
  parameter int unsigned DRW = 102,
  parameter int unsigned SW  = 68,
  parameter int unsigned RW  = 15,
  parameter int unsigned BIT = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic signed [DRW-1:0] d_i,
  input  wire logic signed [DRW-1:0] b_i,
  input  wire logic        [RW-1:0]  r_i,
  input  wire logic        [SW-1:0]  s_i,
  output logic signed      [DRW-1:0] d_o,
  output logic signed      [DRW-1:0] b_o,
  output logic             [RW-1:0]  r_o
);
  logic signed [DRW-1:0] s_ext;
  logic signed [DRW-1:0] sub;
  logic signed [DRW-1:0] dn;
  logic                  take;
  logic signed [DRW-1:0] d_d, b_d, d_q, b_q;
  logic        [RW-1:0]  r_d, r_q;

  // residual D = lim - (2r-1)^2 s, B = (2r-1) s; trial r + 2^BIT
  always_comb begin
    s_ext = $signed({{(DRW-SW){1'b0}}, s_i});
    sub   = (b_i <<< (BIT + 2)) + (s_ext <<< (2 * BIT + 2));
    dn    = d_i - sub;
    take  = ~dn[DRW-1];
    d_d   = take ? dn : d_i;
    b_d   = take ? (b_i + (s_ext <<< (BIT + 1))) : b_i;
    r_d   = r_i | (RW'(take) << BIT);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
      b_q <= b_d;
      r_q <= r_d;
    end
  end

  assign d_o = d_q;
  assign b_o = b_q;
  assign r_o = r_q;
endmodule
`default_nettype wire

// File: rtl/triangle_face_normal.sv
// Top level: unit face normal of a triangle, pipelined
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+----------------------------------------
//  in      | in_valid_i | in_stall_o | a_*_i, b_*_i, c_*_i (signed Q8.8)
//  out     | out_valid_o| out_stall_i| norm_*_o (signed Q1.14), degenerate_o
//
//  One word per clock while out_stall_i is low: five stages for edges,
//  products, cross product, squares and sum, one stage per result bit of the
//  root division, one output register.
//  Each stage holds while it is full and the next one holds, so empty stages fill.
//  Reset clears the valid bits only.
`default_nettype none
`include "triangle_face_normal_assert.svh"
module triangle_face_normal #(
  parameter int unsigned COORD_BITS    = tfn_pkg::COORD_BITS_DEF,
  parameter int unsigned OUT_FRAC_BITS = tfn_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [COORD_BITS-1:0]  a_x_i,
  input  wire logic signed [COORD_BITS-1:0]  a_y_i,
  input  wire logic signed [COORD_BITS-1:0]  a_z_i,
  input  wire logic signed [COORD_BITS-1:0]  b_x_i,
  input  wire logic signed [COORD_BITS-1:0]  b_y_i,
  input  wire logic signed [COORD_BITS-1:0]  b_z_i,
  input  wire logic signed [COORD_BITS-1:0]  c_x_i,
  input  wire logic signed [COORD_BITS-1:0]  c_y_i,
  input  wire logic signed [COORD_BITS-1:0]  c_z_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [tfn_pkg::NORM_W-1:0]  norm_x_o,
  output logic signed [tfn_pkg::NORM_W-1:0]  norm_y_o,
  output logic signed [tfn_pkg::NORM_W-1:0]  norm_z_o,
  output logic                               degenerate_o
);
  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned F    = OUT_FRAC_BITS;
  localparam int unsigned L    = tfn_pkg::LANES;
  localparam int unsigned NW   = tfn_pkg::NORM_W;
  localparam int unsigned MW   = 2 * C + 1;
  localparam int unsigned SQW  = 2 * MW;
  localparam int unsigned SW   = SQW + 2;
  localparam int unsigned DRW  = SQW + 2 * F + 8;
  localparam int unsigned RW   = F + 1;
  localparam int unsigned NB   = F + 1;
  localparam int unsigned NS   = F + 7;
  localparam int unsigned XW   = (RW + 1 > NW) ? RW + 1 : NW;

  // stage valid bits and advance chain
  logic [NS-1:0] v_q;
  logic [NS:0]   adv;

  always_comb begin
    adv[NS] = ~out_stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = ~v_q[k] | adv[k+1];
    end
  end

  assign in_stall_o = ~adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 0: edge vectors Q = a - b, P = c - b
  logic signed [C:0] dq_q [L];
  logic signed [C:0] dp_q [L];
  logic signed [C-1:0] av [L];
  logic signed [C-1:0] bv [L];
  logic signed [C-1:0] cv [L];

  assign av[0] = a_x_i; assign av[1] = a_y_i; assign av[2] = a_z_i;
  assign bv[0] = b_x_i; assign bv[1] = b_y_i; assign bv[2] = b_z_i;
  assign cv[0] = c_x_i; assign cv[1] = c_y_i; assign cv[2] = c_z_i;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int i = 0; i < L; i++) begin
        dq_q[i] <= (C+1)'(av[i]) - (C+1)'(bv[i]);
        dp_q[i] <= (C+1)'(cv[i]) - (C+1)'(bv[i]);
      end
    end
  end

  // stage 1: six products, two per component
  logic signed [2*C+1:0] p1_q [L];
  logic signed [2*C+1:0] p2_q [L];

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int i = 0; i < L; i++) begin
        p1_q[i] <= dp_q[(i+1)%3] * dq_q[(i+2)%3];
        p2_q[i] <= dp_q[(i+2)%3] * dq_q[(i+1)%3];
      end
    end
  end

  // stage 2: cross product as sign and magnitude
  logic signed [2*C+2:0] cr [L];
  logic        [MW-1:0]  mg_q [L];
  logic        [L-1:0]   ng2_q;

  always_comb begin
    for (int i = 0; i < L; i++) begin
      cr[i] = (2*C+3)'(p1_q[i]) - (2*C+3)'(p2_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int i = 0; i < L; i++) begin
        mg_q[i]  <= cr[i][2*C+2] ? MW'(-cr[i]) : MW'(cr[i]);
        ng2_q[i] <= cr[i][2*C+2];
      end
    end
  end

  // stage 3: squares
  logic [SQW-1:0] sq_q [L];
  logic [L-1:0]   ng3_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int i = 0; i < L; i++) begin
        sq_q[i] <= mg_q[i] * mg_q[i];
      end
      ng3_q <= ng2_q;
    end
  end

  // stage 4: squared length and starting residuals
  logic        [SW-1:0]  s_sum;
  logic signed [DRW-1:0] s_sx;

  always_comb begin
    s_sum = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
    s_sx  = $signed({{(DRW-SW){1'b0}}, s_sum});
  end

  logic        [SW-1:0]  s_q   [NB+1];
  logic        [L-1:0]   ng_q  [NB+1];
  logic                  dg_q  [NB+1];
  logic signed [DRW-1:0] d_q   [NB+1][L];
  logic signed [DRW-1:0] bb_q  [NB+1][L];
  logic        [RW-1:0]  r_q   [NB+1][L];

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s_q[0]  <= s_sum;
      ng_q[0] <= ng3_q;
      dg_q[0] <= (s_sum == '0);
      for (int i = 0; i < L; i++) begin
        d_q[0][i]  <= ($signed({{(DRW-SQW){1'b0}}, sq_q[i]}) <<< (2 * F + 2)) - s_sx;
        bb_q[0][i] <= -s_sx;
        r_q[0][i]  <= '0;
      end
    end
  end

  // stages 5 .. F+5: one result bit each, most significant first
  for (genvar j = 1; j <= NB; j++) begin : g_bit
    always_ff @(posedge clk_i) begin
      if (adv[4+j]) begin
        s_q[j]  <= s_q[j-1];
        ng_q[j] <= ng_q[j-1];
        dg_q[j] <= dg_q[j-1];
      end
    end
    for (genvar i = 0; i < L; i++) begin : g_lane
      tfn_root_step #(
        .DRW (DRW),
        .SW  (SW),
        .RW  (RW),
        .BIT (F + 1 - j)
      ) u_step (
        .clk_i (clk_i),
        .en_i  (adv[4+j]),
        .d_i   (d_q[j-1][i]),
        .b_i   (bb_q[j-1][i]),
        .r_i   (r_q[j-1][i]),
        .s_i   (s_q[j-1]),
        .d_o   (d_q[j][i]),
        .b_o   (bb_q[j][i]),
        .r_o   (r_q[j][i])
      );
    end
  end

  // output register: apply sign, zero a degenerate word
  logic [XW-1:0]  sv   [L];
  logic [NW-1:0]  nm_d [L];
  logic [NW-1:0]  nm_q [L];
  logic           dg_out_q;

  always_comb begin
    for (int i = 0; i < L; i++) begin
      sv[i]   = ng_q[NB][i] ? (XW'(0) - XW'(r_q[NB][i])) : XW'(r_q[NB][i]);
      nm_d[i] = dg_q[NB] ? '0 : sv[i][NW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NS-1]) begin
      for (int i = 0; i < L; i++) begin
        nm_q[i] <= nm_d[i];
      end
      dg_out_q <= dg_q[NB];
    end
  end

  assign out_valid_o  = v_q[NS-1];
  assign norm_x_o     = nm_q[0];
  assign norm_y_o     = nm_q[1];
  assign norm_z_o     = nm_q[2];
  assign degenerate_o = dg_out_q;

  `TFN_ASSERT(a_degen_zero, out_valid_o && degenerate_o |-> (norm_x_o == '0) && (norm_y_o == '0) && (norm_z_o == '0))
  `TFN_ASSERT_MSG(a_accept_lands, in_valid_i && !in_stall_o |=> v_q[0], "accepted word lost at entry")
  `TFN_ASSERT_MSG(a_hole_takes, !v_q[0] |-> !in_stall_o, "input stalled with empty entry stage")
endmodule
`default_nettype wire
